// File: hw/rtl/ecc_pkg.sv
// shared types, constants and display glyphs of the evaporator compressor controller
`default_nettype none
package ecc_pkg;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_HYSTERESIS    = 2'd0,
    REG_FREEZE_TARGET = 2'd1,
    REG_KNOB_THRESH   = 2'd2,
    REG_SHOW_MS       = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [6:0]         hysteresis_tenths;
    logic signed [9:0]  freeze_target_tenths;
    logic [9:0]         knob_move_threshold;
    logic [15:0]        setpoint_show_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] temp;
    logic [9:0]         knob;
    logic               button;
    logic               perm;
    logic               bypass;
    logic [31:0]        now;
    logic [7:0]         setpoint;
  } item_t;

  typedef struct packed {
    logic freeze_active;
    logic freeze_finished;
    logic showing_setpoint;
  } status_t;

  localparam logic [6:0]        HystReset = 7'd10;
  localparam logic signed [9:0] FreezeTargetReset = -10'sd50;
  localparam logic [9:0]        KnobThreshReset = 10'd5;
  localparam logic [15:0]       ShowMsReset = 16'd3000;

  localparam logic [7:0] SetpointBase = 8'd50;

  localparam logic [7:0] SEG_DEGREE = 8'b01100011;
  localparam logic [7:0] SEG_C      = 8'b00111001;
  localparam logic [7:0] SEG_O      = 8'b00111111;
  localparam logic [7:0] SEG_L      = 8'b00111000;
  localparam logic [7:0] SEG_W      = 8'b00111110;
  localparam logic [7:0] SEG_A      = 8'b01110111;
  localparam logic [7:0] SEG_I      = 8'b00000110;
  localparam logic [7:0] SEG_T      = 8'b01111000;

  localparam logic [7:0] HEX_GLYPH [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

endpackage
`default_nettype wire

// File: hw/rtl/ecc_cfg_regs.sv
// configuration register bank
`default_nettype none
module ecc_cfg_regs
  import ecc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hysteresis_tenths    <= HystReset;
      cfg.freeze_target_tenths <= FreezeTargetReset;
      cfg.knob_move_threshold  <= KnobThreshReset;
      cfg.setpoint_show_ms     <= ShowMsReset;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_HYSTERESIS:    cfg.hysteresis_tenths    <= cfg_data[6:0];
        REG_FREEZE_TARGET: cfg.freeze_target_tenths <= $signed(cfg_data[9:0]);
        REG_KNOB_THRESH:   cfg.knob_move_threshold  <= cfg_data[9:0];
        REG_SHOW_MS:       cfg.setpoint_show_ms     <= cfg_data[15:0];
        default:           cfg.setpoint_show_ms     <= cfg.setpoint_show_ms;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ecc_front.sv
// input register with knob to setpoint scaling
`default_nettype none
module ecc_front
  import ecc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [11:0] evap_temp_tenths,
  input  wire logic [9:0]         knob_raw,
  input  wire logic               freeze_button,
  input  wire logic               ac_permission,
  input  wire logic               bypass_switch,
  input  wire logic [31:0]        now_ms,
  input  wire logic               advance,
  output logic                    front_valid,
  output item_t                   item
);

  logic [17:0] scaled;
  logic [17:0] scaled_sum;
  logic [7:0]  quot_est;
  logic [17:0] rem_est;
  logic [7:0]  quot;

  // knob * 130 / 1023: reciprocal estimate, then one correction step
  always_comb begin
    scaled     = {1'b0, knob_raw, 7'd0} + {7'd0, knob_raw, 1'b0};
    scaled_sum = scaled + {10'd0, scaled[17:10]};
    quot_est   = scaled_sum[17:10];
    rem_est    = scaled - {quot_est, 10'd0} + {10'd0, quot_est};
    quot       = (rem_est >= 18'd1023) ? quot_est + 8'd1 : quot_est;
  end

  assign in_stall = front_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (!in_stall) begin
      front_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.temp     <= evap_temp_tenths;
      item.knob     <= knob_raw;
      item.button   <= freeze_button;
      item.perm     <= ac_permission;
      item.bypass   <= bypass_switch;
      item.now      <= now_ms;
      item.setpoint <= SetpointBase + quot;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ecc_ctrl.sv
// control state, display formatting and result register
`default_nettype none
module ecc_ctrl
  import ecc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  front_valid,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  input  wire logic  out_stall,
  output logic       advance,
  output logic       out_valid,
  output logic       ac_request,
  output logic       compressor_on,
  output logic       blower_cut,
  output logic       blower_full,
  output logic [7:0] seg_first,
  output logic [7:0] seg_second,
  output logic [7:0] seg_third,
  output logic [7:0] seg_fourth,
  output status_t    status
);

  logic        freeze_active;
  logic        freeze_finished;
  logic [9:0]  last_knob;
  logic [31:0] knob_moved_at;
  logic        showing_setpoint;

  logic        freeze_active_next;
  logic        freeze_finished_next;
  logic [9:0]  last_knob_next;
  logic [31:0] knob_moved_at_next;
  logic        showing_setpoint_next;

  logic        fire;
  logic [9:0]  knob_diff;
  logic        knob_moved;
  logic        show_now;
  logic        freeze_run;
  logic        above_target;
  logic signed [12:0] temp_x;
  logic signed [12:0] target_x;
  logic signed [12:0] limit_x;
  logic        need;
  logic        cut;
  logic        full;
  logic [31:0] elapsed;

  logic        temp_neg;
  logic [11:0] temp_mag;
  logic [23:0] prod_tenth;
  logic [22:0] prod_hund;
  logic [8:0]  deg_mag;
  logic [4:0]  deg_tens;
  logic [3:0]  tens_mag;
  logic [3:0]  units_mag;
  logic [3:0]  temp_tens_dig;
  logic [3:0]  temp_units_dig;

  logic [15:0] sp_prod;
  logic [4:0]  sp_deg;
  logic [3:0]  sp_tens_dig;
  logic [3:0]  sp_units_dig;

  logic [7:0]  seg0;
  logic [7:0]  seg1;
  logic [7:0]  seg2;
  logic [7:0]  seg3;

  assign advance = !out_valid || !out_stall;
  assign fire    = front_valid && advance;

  assign status.freeze_active    = freeze_active;
  assign status.freeze_finished  = freeze_finished;
  assign status.showing_setpoint = showing_setpoint;

  // temperature in whole degrees, truncated toward zero, digit by digit
  always_comb begin
    temp_neg   = item.temp[11];
    temp_mag   = temp_neg ? 12'd0 - item.temp : item.temp;
    prod_tenth = 24'(temp_mag) * 24'd3277;
    prod_hund  = 23'(temp_mag) * 23'd1311;
    deg_mag    = prod_tenth[23:15];
    deg_tens   = prod_hund[21:17];
    priority if (deg_tens >= 5'd20) tens_mag = 4'(deg_tens - 5'd20);
    else if (deg_tens >= 5'd10)     tens_mag = 4'(deg_tens - 5'd10);
    else                            tens_mag = deg_tens[3:0];
    units_mag      = 4'(deg_mag - 9'({deg_tens, 3'd0} + {deg_tens, 1'b0}));
    temp_tens_dig  = temp_neg ? 4'd0 - tens_mag : tens_mag;
    temp_units_dig = temp_neg ? 4'd0 - units_mag : units_mag;
  end

  // setpoint in whole degrees
  always_comb begin
    sp_prod = 16'(item.setpoint) * 16'd205;
    sp_deg  = sp_prod[15:11];
    priority if (sp_deg >= 5'd20) begin
      sp_tens_dig  = 4'd2;
      sp_units_dig = 4'(sp_deg - 5'd20);
    end else if (sp_deg >= 5'd10) begin
      sp_tens_dig  = 4'd1;
      sp_units_dig = 4'(sp_deg - 5'd10);
    end else begin
      sp_tens_dig  = 4'd0;
      sp_units_dig = sp_deg[3:0];
    end
  end

  always_comb begin
    knob_diff  = (item.knob >= last_knob) ? item.knob - last_knob : last_knob - item.knob;
    knob_moved = knob_diff > cfg.knob_move_threshold;

    last_knob_next     = knob_moved ? item.knob : last_knob;
    knob_moved_at_next = knob_moved ? item.now : knob_moved_at;
    show_now           = knob_moved || showing_setpoint;

    freeze_run   = freeze_active || (item.button && !freeze_finished);
    temp_x       = {item.temp[11], item.temp};
    target_x     = {{3{cfg.freeze_target_tenths[9]}}, cfg.freeze_target_tenths};
    limit_x      = $signed({5'd0, item.setpoint}) + $signed({6'd0, cfg.hysteresis_tenths});
    above_target = temp_x > target_x;

    priority if (freeze_run) need = above_target;
    else if (!freeze_finished) need = temp_x > limit_x;
    else need = 1'b0;

    cut  = freeze_run;
    full = freeze_run && !above_target;
    freeze_active_next   = freeze_run && above_target;
    freeze_finished_next = freeze_finished || full;

    elapsed               = item.now - knob_moved_at_next;
    showing_setpoint_next = show_now;

    priority if (freeze_active_next) begin
      seg0 = SEG_C;
      seg1 = SEG_O;
      seg2 = SEG_O;
      seg3 = SEG_L;
    end else if (need && !item.perm && !item.bypass) begin
      seg0 = SEG_W;
      seg1 = SEG_A;
      seg2 = SEG_I;
      seg3 = SEG_T;
    end else if (show_now) begin
      seg0 = HEX_GLYPH[sp_tens_dig];
      seg1 = HEX_GLYPH[sp_units_dig];
      seg2 = SEG_DEGREE;
      seg3 = SEG_C;
      showing_setpoint_next = !(elapsed > {16'd0, cfg.setpoint_show_ms});
    end else begin
      seg0 = HEX_GLYPH[temp_tens_dig];
      seg1 = HEX_GLYPH[temp_units_dig];
      seg2 = SEG_DEGREE;
      seg3 = SEG_C;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freeze_active    <= 1'b0;
      freeze_finished  <= 1'b0;
      last_knob        <= '0;
      knob_moved_at    <= '0;
      showing_setpoint <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= front_valid;
      end
      if (fire) begin
        freeze_active    <= freeze_active_next;
        freeze_finished  <= freeze_finished_next;
        last_knob        <= last_knob_next;
        knob_moved_at    <= knob_moved_at_next;
        showing_setpoint <= showing_setpoint_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ac_request    <= need;
      compressor_on <= need && (item.perm || item.bypass);
      blower_cut    <= cut;
      blower_full   <= full;
      seg_first     <= seg0;
      seg_second    <= seg1;
      seg_third     <= seg2;
      seg_fourth    <= seg3;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/evaporator_compressor_controller_core.sv
// top level of the evaporator compressor controller
//
// one request on the input channel is one control cycle: temperature, knob,
// switches and a millisecond time stamp. each request gives exactly one
// result: ac request, compressor relay, blower cut and blower full, and the
// four segment patterns of the display, leftmost first.
// both channels use valid and stall; a transfer happens at a clock edge with
// valid high and stall low.
// input acceptance and the first edge at which the result can be taken are
// separated by one input register and one result register, with the control
// logic between them.
// throughput is one request per clock unless the receiver stalls; a new
// request is taken while a finished result waits, as long as the input
// register is free. when the receiver stalls, the result holds, the input
// register fills and then in_stall rises until the result is taken.
// the user writes configuration registers through cfg_we, cfg_index, cfg_data
// only while the block is idle; the block itself leaves this unchecked.
// synchronous reset clears both pipeline stages, the freeze cleaning state,
// the knob tracking and loads the register defaults.
`default_nettype none
module evaporator_compressor_controller_core
  import ecc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [11:0]       evap_temp_tenths,
  input  wire logic [9:0]               knob_raw,
  input  wire logic                     freeze_button,
  input  wire logic                     ac_permission,
  input  wire logic                     bypass_switch,
  input  wire logic [31:0]              now_ms,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          ac_request,
  output logic                          compressor_on,
  output logic                          blower_cut,
  output logic                          blower_full,
  output logic [7:0]                    seg_first,
  output logic [7:0]                    seg_second,
  output logic [7:0]                    seg_third,
  output logic [7:0]                    seg_fourth
);

  cfg_t    cfg;
  item_t   item;
  status_t status;
  logic    front_valid;
  logic    advance;

  ecc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ecc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .evap_temp_tenths (evap_temp_tenths),
    .knob_raw         (knob_raw),
    .freeze_button    (freeze_button),
    .ac_permission    (ac_permission),
    .bypass_switch    (bypass_switch),
    .now_ms           (now_ms),
    .advance          (advance),
    .front_valid      (front_valid),
    .item             (item)
  );

  ecc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .front_valid   (front_valid),
    .item          (item),
    .cfg           (cfg),
    .out_stall     (out_stall),
    .advance       (advance),
    .out_valid     (out_valid),
    .ac_request    (ac_request),
    .compressor_on (compressor_on),
    .blower_cut    (blower_cut),
    .blower_full   (blower_full),
    .seg_first     (seg_first),
    .seg_second    (seg_second),
    .seg_third     (seg_third),
    .seg_fourth    (seg_fourth),
    .status        (status)
  );

  a_freeze_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.freeze_active && status.freeze_finished))
    else $error("freeze cleaning active and finished together");

  a_full_sets_finished: assert property (@(posedge clk) disable iff (rst)
    (out_valid && blower_full) |-> (status.freeze_finished && blower_cut))
    else $error("blower full without finished freeze cleaning");

  a_compressor_needs_request: assert property (@(posedge clk) disable iff (rst)
    (out_valid && compressor_on) |-> ac_request)
    else $error("compressor on without ac request");

  a_finished_no_request: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !blower_full && $past(status.freeze_finished) && status.freeze_finished)
      |-> !ac_request)
    else $error("ac requested after freeze cleaning finished");

endmodule
`default_nettype wire
